FILE: hdl/mwbcg_pkg.sv
// ----------------------------------------------------------------------------
// Mesh-warp block coordinate generator: shared package
// Field widths, register indexes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package mwbcg_pkg;

  localparam int CORNER_W = 16;  // input corner coordinate
  localparam int POS_W    = 20;  // internal signed point / step
  localparam int DIM_W    = 13;  // frame dimension register
  localparam int LOG_W    = 2;   // grid log register
  localparam int CNT_W    = 3;   // pixel column / row in block
  localparam int SRC_W    = 12;  // source coordinate output
  localparam int IDX_W    = 24;  // source address output
  localparam int CIDX_W   = 2;   // configuration index

  localparam logic [CIDX_W-1:0] CFG_GRID_LOG     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch corners, compute edge steps
    logic row_init;   // start a row: line point and column step
    logic clamp;      // clamp the current point into the frame
    logic issue;      // load the output word
    logic line_adv;   // advance along the row
    logic edge_adv;   // advance both edges to the next row
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a word
    logic col_last;   // current pixel ends its row
    logic row_last;   // current row ends the block
  } sts_t;

  // Sign-extend a corner coordinate to the internal point width.
  function automatic logic signed [POS_W-1:0] ext_pos(input logic [CORNER_W-1:0] v);
    ext_pos = $signed({{(POS_W-CORNER_W){v[CORNER_W-1]}}, v});
  endfunction

endpackage

FILE: hdl/mesh_warp_block_coordinate_generator_top.sv
// ----------------------------------------------------------------------------
// Mesh-warp block coordinate generator: top level
// Turns one grid cell of four displaced corners into per-pixel source points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word is one grid cell, the four
//   displaced corners. The block walks the 2^L x 2^L block in row-major order
//   and sends one output word per pixel (out_valid/out_ready) with the clamped
//   source column/row, the linear source address, the pixel position and a
//   last flag on the final pixel.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 grid log,
//   1 frame width, 2 frame height. Write only while the block is idle.
//   Sequence: the accept loads the corners and edge steps, each row has a
//   setup step, and each pixel two steps (clamp, then address multiply into
//   the output register). The two-step pixel loop of the controller sets the
//   rate. in_ready is high only between blocks, and a new cell is taken while
//   the last word of the previous one still waits.
//   Stall: a pending output word holds the pixel loop; nothing is dropped.
//   Reset: synchronous; registers return to grid log 1, 640 x 480, the
//   controller to idle and the output register to empty.
// ----------------------------------------------------------------------------
module mesh_warp_block_coordinate_generator_top
  import mwbcg_pkg::*;
#(
  parameter int MAX_FRAME_DIM = 4096,
  parameter int MAX_GRID_LOG  = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CORNER_W-1:0] upper_left_x,
  input  logic [CORNER_W-1:0] upper_left_y,
  input  logic [CORNER_W-1:0] upper_right_x,
  input  logic [CORNER_W-1:0] upper_right_y,
  input  logic [CORNER_W-1:0] lower_left_x,
  input  logic [CORNER_W-1:0] lower_left_y,
  input  logic [CORNER_W-1:0] lower_right_x,
  input  logic [CORNER_W-1:0] lower_right_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SRC_W-1:0]    source_x,
  output logic [SRC_W-1:0]    source_y,
  output logic [IDX_W-1:0]    source_index,
  output logic [CNT_W-1:0]    block_col,
  output logic [CNT_W-1:0]    block_row,
  output logic                last
);

  logic [LOG_W-1:0] grid_size_log;
  logic [DIM_W-1:0] frame_width, frame_height;
  logic [LOG_W-1:0] eff_log;
  logic [DIM_W-1:0] eff_width, eff_height;
  cmd_t             cmd;
  sts_t             sts;

  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size_log <= LOG_W'(1);
      frame_width   <= DIM_W'(640);
      frame_height  <= DIM_W'(480);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_LOG:     grid_size_log <= cfg_data[LOG_W-1:0];
        CFG_FRAME_WIDTH:  frame_width   <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // effective settings: grid log 0 acts as 1 and caps at MAX_GRID_LOG, sizes clamp to [1, MAX_FRAME_DIM]
  always_comb begin
    if (grid_size_log == '0) begin
      eff_log = LOG_W'(1);
    end else if (32'(grid_size_log) > MAX_GRID_LOG) begin
      eff_log = LOG_W'(MAX_GRID_LOG);
    end else begin
      eff_log = grid_size_log;
    end
    if (frame_width == '0) begin
      eff_width = DIM_W'(1);
    end else if (32'(frame_width) > MAX_FRAME_DIM) begin
      eff_width = DIM_W'(MAX_FRAME_DIM);
    end else begin
      eff_width = frame_width;
    end
    if (frame_height == '0) begin
      eff_height = DIM_W'(1);
    end else if (32'(frame_height) > MAX_FRAME_DIM) begin
      eff_height = DIM_W'(MAX_FRAME_DIM);
    end else begin
      eff_height = frame_height;
    end
  end

  mwbcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mwbcg_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .grid_log      (eff_log),
    .eff_width     (eff_width),
    .eff_height    (eff_height),
    .upper_left_x  (upper_left_x),
    .upper_left_y  (upper_left_y),
    .upper_right_x (upper_right_x),
    .upper_right_y (upper_right_y),
    .lower_left_x  (lower_left_x),
    .lower_left_y  (lower_left_y),
    .lower_right_x (lower_right_x),
    .lower_right_y (lower_right_y),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .source_x      (source_x),
    .source_y      (source_y),
    .source_index  (source_index),
    .block_col     (block_col),
    .block_row     (block_row),
    .last          (last)
  );

endmodule

FILE: hdl/mwbcg_ctrl.sv
// ----------------------------------------------------------------------------
// Mesh-warp block coordinate generator: controller
// Sequences load, row setup, clamp and issue for every pixel of a block.
// ----------------------------------------------------------------------------
module mwbcg_ctrl
  import mwbcg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROW   = 4'b0010,
    S_CLAMP = 4'b0100,
    S_ISSUE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        cmd.row_init = 1'b1;
        state_next   = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.issue = 1'b1;
          if (!sts.col_last) begin
            cmd.line_adv = 1'b1;
            state_next   = S_CLAMP;
          end else if (!sts.row_last) begin
            cmd.edge_adv = 1'b1;
            state_next   = S_ROW;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/mwbcg_dp.sv
// ----------------------------------------------------------------------------
// Mesh-warp block coordinate generator: datapath
// Edge and line interpolation, frame clamping, address multiply, output word.
// ----------------------------------------------------------------------------
module mwbcg_dp
  import mwbcg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [LOG_W-1:0]    grid_log,
  input  logic [DIM_W-1:0]    eff_width,
  input  logic [DIM_W-1:0]    eff_height,
  input  logic [CORNER_W-1:0] upper_left_x,
  input  logic [CORNER_W-1:0] upper_left_y,
  input  logic [CORNER_W-1:0] upper_right_x,
  input  logic [CORNER_W-1:0] upper_right_y,
  input  logic [CORNER_W-1:0] lower_left_x,
  input  logic [CORNER_W-1:0] lower_left_y,
  input  logic [CORNER_W-1:0] lower_right_x,
  input  logic [CORNER_W-1:0] lower_right_y,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [SRC_W-1:0]    source_x,
  output logic [SRC_W-1:0]    source_y,
  output logic [IDX_W-1:0]    source_index,
  output logic [CNT_W-1:0]    block_col,
  output logic [CNT_W-1:0]    block_row,
  output logic                last
);

  logic signed [POS_W-1:0] row_start_x, row_start_y, row_end_x, row_end_y;
  logic signed [POS_W-1:0] step_sx, step_sy, step_ex, step_ey;
  logic signed [POS_W-1:0] line_x, line_y, step_lx, step_ly;
  logic [CNT_W-1:0]        col, row;
  logic [DIM_W-1:0]        sx_c, sy_c;

  logic signed [POS_W-1:0] diff_sx, diff_sy, diff_ex, diff_ey, diff_lx, diff_ly;
  logic [DIM_W-1:0]        w_m1, h_m1, sx_next, sy_next;
  logic [CNT_W-1:0]        size_m1;
  logic [2*DIM_W-1:0]      prod, idx_sum;

  assign size_m1 = CNT_W'((4'd1 << grid_log) - 4'd1);

  assign diff_sx = ext_pos(lower_left_x) - ext_pos(upper_left_x);
  assign diff_sy = ext_pos(lower_left_y) - ext_pos(upper_left_y);
  assign diff_ex = ext_pos(lower_right_x) - ext_pos(upper_right_x);
  assign diff_ey = ext_pos(lower_right_y) - ext_pos(upper_right_y);
  assign diff_lx = row_end_x - row_start_x;
  assign diff_ly = row_end_y - row_start_y;

  assign w_m1 = eff_width - DIM_W'(1);
  assign h_m1 = eff_height - DIM_W'(1);

  // clamp the current point into [0, dim-1]
  always_comb begin
    if (line_x < 0) begin
      sx_next = '0;
    end else if (line_x > $signed({{(POS_W-DIM_W){1'b0}}, w_m1})) begin
      sx_next = w_m1;
    end else begin
      sx_next = line_x[DIM_W-1:0];
    end
    if (line_y < 0) begin
      sy_next = '0;
    end else if (line_y > $signed({{(POS_W-DIM_W){1'b0}}, h_m1})) begin
      sy_next = h_m1;
    end else begin
      sy_next = line_y[DIM_W-1:0];
    end
  end

  assign prod    = sy_c * eff_width;
  assign idx_sum = prod + (2*DIM_W)'(sx_c);

  assign sts.out_free = !out_valid || out_ready;
  assign sts.col_last = (col == size_m1);
  assign sts.row_last = (row == size_m1);

  // interpolation state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_start_x <= ext_pos(upper_left_x);
      row_start_y <= ext_pos(upper_left_y);
      row_end_x   <= ext_pos(upper_right_x);
      row_end_y   <= ext_pos(upper_right_y);
      step_sx     <= diff_sx >>> grid_log;
      step_sy     <= diff_sy >>> grid_log;
      step_ex     <= diff_ex >>> grid_log;
      step_ey     <= diff_ey >>> grid_log;
    end else if (cmd.edge_adv) begin
      row_start_x <= row_start_x + step_sx;
      row_start_y <= row_start_y + step_sy;
      row_end_x   <= row_end_x + step_ex;
      row_end_y   <= row_end_y + step_ey;
    end
    if (cmd.row_init) begin
      line_x  <= row_start_x;
      line_y  <= row_start_y;
      step_lx <= diff_lx >>> grid_log;
      step_ly <= diff_ly >>> grid_log;
    end else if (cmd.line_adv) begin
      line_x <= line_x + step_lx;
      line_y <= line_y + step_ly;
    end
    if (cmd.clamp) begin
      sx_c <= sx_next;
      sy_c <= sy_next;
    end
  end

  // pixel counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      if (cmd.load) begin
        row <= '0;
      end else if (cmd.edge_adv) begin
        row <= row + CNT_W'(1);
      end
      if (cmd.row_init) begin
        col <= '0;
      end else if (cmd.line_adv) begin
        col <= col + CNT_W'(1);
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      source_x     <= sx_c[SRC_W-1:0];
      source_y     <= sy_c[SRC_W-1:0];
      source_index <= idx_sum[IDX_W-1:0];
      block_col    <= col;
      block_row    <= row;
      last         <= sts.col_last && sts.row_last;
    end
  end

  a_issue_free: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> sts.out_free)
    else $error("output word issued over a pending word");

  a_load_row: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (row == '0))
    else $error("row counter not cleared on load");

  a_row_init: assert property (@(posedge clk) disable iff (rst)
    cmd.row_init |=> (col == '0) && (line_x == $past(row_start_x))
                     && (line_y == $past(row_start_y)))
    else $error("row setup did not seed the line point");

endmodule

FILE: dv/mesh_warp_block_coordinate_generator_top_test.sv
// ----------------------------------------------------------------------------
// Mesh-warp block coordinate generator: testbench
// Feeds grid cells and register settings, predicts every pixel word of each
// block and checks the output stream word by word under random idling.
// ----------------------------------------------------------------------------
module mesh_warp_block_coordinate_generator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mwbcg_pkg::*;

  localparam int FRAME_CAP  = 4096;
  localparam int LOG_CAP    = 3;
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;  // index with no register behind it

  // One grid cell, in port order.
  typedef struct packed {
    logic [CORNER_W-1:0] ul_x, ul_y, ur_x, ur_y, ll_x, ll_y, lr_x, lr_y;
  } cell_t;

  // One pixel word, in port order.
  typedef struct packed {
    logic [SRC_W-1:0] sx;
    logic [SRC_W-1:0] sy;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             last_px;
  } point_t;

  // Holds a copy of the registers and the pixel words still owed by the block.
  class source_point_book;
    point_t           points_due[$];
    int               errors;
    logic [LOG_W-1:0] grid_log;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;

    function new();
      grid_log = 1;
      width    = 640;
      height   = 480;
      errors   = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] index, logic [DIM_W-1:0] data);
      case (index)
        CFG_GRID_LOG:     grid_log = data[LOG_W-1:0];
        CFG_FRAME_WIDTH:  width = data;
        CFG_FRAME_HEIGHT: height = data;
        default: ;
      endcase
    endfunction

    function int eff_log();
      if (grid_log == 0) return 1;
      if (grid_log > LOG_CAP) return LOG_CAP;
      return grid_log;
    endfunction

    function int eff_dim(logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > FRAME_CAP) return FRAME_CAP;
      return d;
    endfunction

    function int eff_width();
      return eff_dim(width);
    endfunction

    function int eff_height();
      return eff_dim(height);
    endfunction

    function logic signed [POS_W-1:0] widen(logic [CORNER_W-1:0] v);
      return $signed(v);
    endfunction

    function logic [SRC_W-1:0] clamp_into(logic signed [POS_W-1:0] v, int dim);
      int vi;
      vi = v;
      if (vi < 0) return '0;
      if (vi > dim - 1) return SRC_W'(dim - 1);
      return SRC_W'(vi);
    endfunction

    // Walk the block row by row and queue one word per pixel.
    function void add_cell(cell_t c);
      int lg, s, w, h, r, k;
      logic signed [POS_W-1:0] left_x, left_y, right_x, right_y;
      logic signed [POS_W-1:0] dlx, dly, drx, dry, px, py, dpx, dpy;
      point_t p;
      lg = eff_log();
      s  = 1 << lg;
      w  = eff_width();
      h  = eff_height();
      left_x  = widen(c.ul_x);
      left_y  = widen(c.ul_y);
      right_x = widen(c.ur_x);
      right_y = widen(c.ur_y);
      dlx = (widen(c.ll_x) - left_x) >>> lg;
      dly = (widen(c.ll_y) - left_y) >>> lg;
      drx = (widen(c.lr_x) - right_x) >>> lg;
      dry = (widen(c.lr_y) - right_y) >>> lg;
      for (r = 0; r < s; r++) begin
        px  = left_x;
        py  = left_y;
        dpx = (right_x - left_x) >>> lg;
        dpy = (right_y - left_y) >>> lg;
        for (k = 0; k < s; k++) begin
          p.sx      = clamp_into(px, w);
          p.sy      = clamp_into(py, h);
          p.idx     = IDX_W'(int'(p.sx) + int'(p.sy) * w);
          p.col     = CNT_W'(k);
          p.row     = CNT_W'(r);
          p.last_px = (r == s - 1) && (k == s - 1);
          points_due.push_back(p);
          px += dpx;
          py += dpy;
        end
        left_x  += dlx;
        left_y  += dly;
        right_x += drx;
        right_y += dry;
      end
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_word(point_t got);
      point_t want;
      if (points_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual x=%0d y=%0d idx=%0d",
                 $time, got.sx, got.sy, got.idx);
        return;
      end
      want = points_due.pop_front();
      compare("source_x", want.sx, got.sx);
      compare("source_y", want.sy, got.sy);
      compare("source_index", want.idx, got.idx);
      compare("block_col", want.col, got.col);
      compare("block_row", want.row, got.row);
      compare("last", want.last_px, got.last_px);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [DIM_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CORNER_W-1:0] upper_left_x = '0, upper_left_y = '0;
  logic [CORNER_W-1:0] upper_right_x = '0, upper_right_y = '0;
  logic [CORNER_W-1:0] lower_left_x = '0, lower_left_y = '0;
  logic [CORNER_W-1:0] lower_right_x = '0, lower_right_y = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic [SRC_W-1:0]    source_x, source_y;
  logic [IDX_W-1:0]    source_index;
  logic [CNT_W-1:0]    block_col, block_row;
  logic                last;

  source_point_book book;
  int send_idle_pct = 0;  // chance of a gap after each cell
  int stall_pct     = 0;  // chance of the receiver starting a stall
  int stall_left    = 0;

  mesh_warp_block_coordinate_generator_top #(
    .MAX_FRAME_DIM(FRAME_CAP),
    .MAX_GRID_LOG (LOG_CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .upper_left_x (upper_left_x),
    .upper_left_y (upper_left_y),
    .upper_right_x(upper_right_x),
    .upper_right_y(upper_right_y),
    .lower_left_x (lower_left_x),
    .lower_left_y (lower_left_y),
    .lower_right_x(lower_right_x),
    .lower_right_y(lower_right_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .source_x     (source_x),
    .source_y     (source_y),
    .source_index (source_index),
    .block_col    (block_col),
    .block_row    (block_row),
    .last         (last)
  );

  always #4 clk = ~clk;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int idle_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 6) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sample every handshake at the edge that completes it. Registers are
  // noted before cells so that a cell is predicted with the settings in force.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        book.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        book.add_cell({upper_left_x, upper_left_y, upper_right_x, upper_right_y,
                       lower_left_x, lower_left_y, lower_right_x, lower_right_y});
      if (out_valid && out_ready)
        book.check_word({source_x, source_y, source_index, block_col, block_row, last});
    end
  end

  // Receiver: drop ready for random stretches; one assignment per edge.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct)
        stall_left <= idle_gap(100);
    end
  end

  // Hold valid and the corners until the cell is taken, then maybe pause.
  // Valid stays high across back-to-back cells.
  task automatic send_cell(cell_t c);
    int gap;
    in_valid <= 1'b1;
    {upper_left_x, upper_left_y, upper_right_x, upper_right_y,
     lower_left_x, lower_left_y, lower_right_x, lower_right_y} <= c;
    do @(posedge clk); while (!in_ready);
    gap = idle_gap(send_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Leaves cfg_valid high so a run of writes stays back to back.
  task automatic write_reg(logic [CIDX_W-1:0] index, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(logic [DIM_W-1:0] log_word, logic [DIM_W-1:0] w,
                               logic [DIM_W-1:0] h);
    write_reg(CFG_GRID_LOG, log_word);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait for the last owed word; the block is idle after it.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.points_due.size() != 0) @(posedge clk);
  endtask

  function automatic cell_t corners(int ulx, int uly, int urx, int ury,
                                    int llx, int lly, int lrx, int lry);
    cell_t c;
    c.ul_x = 16'(ulx); c.ul_y = 16'(uly);
    c.ur_x = 16'(urx); c.ur_y = 16'(ury);
    c.ll_x = 16'(llx); c.ll_y = 16'(lly);
    c.lr_x = 16'(lrx); c.lr_y = 16'(lry);
    return c;
  endfunction

  function automatic int jitter(int j);
    return int'($urandom_range(0, 2 * j)) - j;
  endfunction

  // Mostly a plausible warped square near the frame, sometimes raw noise.
  function automatic cell_t make_cell();
    cell_t c;
    int s, span, bx, by, j;
    if ($urandom_range(0, 9) < 3) begin
      c = {$urandom, $urandom, $urandom, $urandom};
      return c;
    end
    s    = 1 << book.eff_log();
    span = s;
    if ($urandom_range(0, 3) == 0) span = s * $urandom_range(2, 40);
    if ($urandom_range(0, 7) == 0) span = -span;
    j  = $urandom_range(0, 2) * s;
    bx = $urandom_range(0, book.eff_width() + 2 * s) - s;
    by = $urandom_range(0, book.eff_height() + 2 * s) - s;
    return corners(bx + jitter(j), by + jitter(j), bx + span + jitter(j), by + jitter(j),
                   bx + jitter(j), by + span + jitter(j),
                   bx + span + jitter(j), by + span + jitter(j));
  endfunction

  // Frame size pick with the extremes and the out-of-range codes well represented.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return FRAME_CAP;
      2:       return 0;
      3:       return DIM_W'($urandom_range(FRAME_CAP + 1, 8191));
      4:       return DIM_W'($urandom_range(1, 64));
      default: return DIM_W'($urandom_range(1, FRAME_CAP));
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 15;
      2:       return 40;
      default: return 70;
    endcase
  endfunction

  // Generous ceiling: even every cell at 64 words behind long stalls ends far sooner.
  initial begin
    #20_000_000;
    $display("mesh_warp_block_coordinate_generator_top verification failed");
    $finish;
  end

  initial begin
    logic [DIM_W-1:0] log_word;
    int               lg;
    book = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: grid log 1 in a 640 x 480 frame.
    send_idle_pct = 30;
    stall_pct     = 30;
    send_cell(corners(0, 0, 2, 0, 0, 2, 2, 2));
    send_cell(corners(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_cell(corners(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_cell(corners(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    send_cell(corners(639, 479, 641, 479, 639, 481, 641, 481));
    // Negative odd differences: the steps must round toward minus infinity.
    send_cell(corners(10, 10, 9, 10, 10, 9, 9, 9));
    send_cell(corners(5, 5, 6, 6, 4, 7, 7, 3));
    send_cell(corners(100, 200, 90, 210, 110, 190, 95, 205));

    // Grid log zero acts as one; zero frame sizes pin everything to the origin.
    wait_idle();
    apply_setting(0, 0, 0);
    send_cell(corners(3, 3, 5, 3, 3, 5, 5, 5));
    send_cell({$urandom, $urandom, $urandom, $urandom});

    // Largest blocks in the largest frame; reach the top address.
    wait_idle();
    apply_setting(3, FRAME_CAP, FRAME_CAP);
    send_cell(corners(4088, 4088, 4096, 4088, 4088, 4096, 4096, 4096));
    send_cell(corners(0, 0, 8, 0, 0, 8, 8, 8));
    send_cell(corners(-4, -4, 12, -8, -2, 10, 9, 14));
    send_cell(corners(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768));

    // Frame sizes past the cap; upper data bits of the grid log write are dropped.
    // Also poke the unused index, which must change nothing.
    wait_idle();
    stall_pct = 0;
    write_reg(CFG_SPARE, 13'h1FFF);
    apply_setting(13'h1FFE, 8191, FRAME_CAP + 1);
    send_cell(corners(4090, 4090, 4100, 4090, 4090, 4100, 4100, 4100));
    send_cell(corners(-3, 1, 1, -3, -7, 5, 5, -7));

    // One-column frame.
    wait_idle();
    apply_setting(1, 1, FRAME_CAP);
    send_cell(corners(-1, 4094, 1, 4094, -1, 4096, 1, 4096));

    // Random phases: fresh settings each time, the first with no idling at all.
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      lg = $urandom_range(0, 19);
      lg = (lg < 2) ? 0 : (lg < 10) ? 1 : (lg < 16) ? 2 : 3;
      log_word = {11'($urandom_range(0, 2047)), 2'(lg)};
      apply_setting(log_word, pick_dim(), pick_dim());
      send_idle_pct = (phase == 0) ? 0 : pick_pct();
      stall_pct     = (phase == 0) ? 0 : pick_pct();
      for (int n = 0; n < 17; n++)
        send_cell(make_cell());
    end

    // Drain, then give a stray word time to show up.
    wait_idle();
    repeat (30) @(posedge clk);
    if (book.points_due.size() != 0)
      $display("%0t: %0d expected words never arrived", $time, book.points_due.size());
    if (book.errors == 0 && book.points_due.size() == 0) begin
      $display("mesh_warp_block_coordinate_generator_top verification clean");
    end else begin
      $display("mesh_warp_block_coordinate_generator_top verification failed");
    end
    $finish;
  end

endmodule
